// ----- rtl/rendezvous_message_queue_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Rendezvous message queue engine: assertion macros
// Checker macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RENDEZVOUS_MESSAGE_QUEUE_ENGINE_DEFINES_SVH
`define RENDEZVOUS_MESSAGE_QUEUE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define RMQE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define RMQE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMQE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RMQE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/rmqe_pkg.sv -----
// ----------------------------------------------------------------------------
// Rendezvous message queue engine package
// Codes, index widths and the structs shared by the sequencer and the cells.
// ----------------------------------------------------------------------------
package rmqe_pkg;

    localparam int MAX_THREADS = 64;
    localparam int THREADS_DEF = 16;
    localparam int TID_W       = $clog2(MAX_THREADS);
    // Link: MSB marks an empty link
    localparam int LNK_W       = TID_W + 1;

    typedef logic [TID_W-1:0] tid_t;
    typedef logic [LNK_W-1:0] lnk_t;

    localparam lnk_t LNK_NIL = '1;

    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_RECV  = 2'd1;
    localparam logic [1:0] REQ_ABORT = 2'd2;

    typedef enum logic [2:0] {
        EV_ERROR      = 3'd0,
        EV_SEND_DONE  = 3'd1,
        EV_BLOCKS     = 3'd2,
        EV_GETS_MSG   = 3'd3,
        EV_WOKEN_OK   = 3'd4,
        EV_WOKEN_FAIL = 3'd5,
        EV_ABORT_DONE = 3'd6
    } event_t;

    // Per-thread state as seen on a read chain
    typedef struct packed {
        logic        snd;
        logic        rcv;
        logic        fany;
        logic [15:0] fpid;
        logic [15:0] hpid;
        logic [31:0] htype;
        logic [63:0] hval;
        tid_t        waits;
        lnk_t        nlink;
        lnk_t        qhead;
        lnk_t        qtail;
    } cell_rd_t;

    typedef struct packed {
        logic        en;
        tid_t        tid;
        logic        snd_we;
        logic        snd;
        logic        rcv_we;
        logic        rcv;
        logic        fany_we;
        logic        fany;
        logic        fpid_we;
        logic [15:0] fpid;
    } flag_wr_t;

    typedef struct packed {
        logic        en;
        tid_t        tid;
        logic [15:0] pid;
        logic [31:0] mtype;
        logic [63:0] mval;
        tid_t        waits;
    } hold_wr_t;

    typedef struct packed {
        logic en;
        tid_t tid;
        lnk_t val;
    } lnk_wr_t;

    // Write bundle broadcast to every cell
    typedef struct packed {
        flag_wr_t flag;
        hold_wr_t hold;
        lnk_wr_t  link;
        lnk_wr_t  head;
        lnk_wr_t  tail;
    } wr_t;

    function automatic lnk_t to_lnk(tid_t t);
        return {1'b0, t};
    endfunction

endpackage

// ----- rtl/rmqe_cell.sv -----
// ----------------------------------------------------------------------------
// Rendezvous message queue engine thread cell
// Holds one thread's flags, filter, held message and queue links, applies
// broadcast writes addressed to it and adds its view to two read chains.
// ----------------------------------------------------------------------------
module rmqe_cell
    import rmqe_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  wr_t      wr,
    input  tid_t     sel_a,
    input  tid_t     sel_b,
    input  cell_rd_t rd_a_in,
    input  cell_rd_t rd_b_in,
    output cell_rd_t rd_a_out,
    output cell_rd_t rd_b_out
);

    localparam tid_t MY_ID = TID_W'(IDX);

    logic        snd_reg, snd_next;
    logic        rcv_reg, rcv_next;
    logic        fany_reg, fany_next;
    logic [15:0] fpid_reg, fpid_next;
    lnk_t        nlink_reg, nlink_next;
    lnk_t        qhead_reg, qhead_next;
    lnk_t        qtail_reg, qtail_next;
    logic [15:0] hpid_reg;
    logic [31:0] htype_reg;
    logic [63:0] hval_reg;
    tid_t        waits_reg;
    logic        hold_hit;
    cell_rd_t    me;

    // Apply writes addressed to this thread
    always_comb
    begin
        snd_next   = snd_reg;
        rcv_next   = rcv_reg;
        fany_next  = fany_reg;
        fpid_next  = fpid_reg;
        nlink_next = nlink_reg;
        qhead_next = qhead_reg;
        qtail_next = qtail_reg;
        if (wr.flag.en && wr.flag.tid == MY_ID)
        begin
            if (wr.flag.snd_we)
                snd_next = wr.flag.snd;
            if (wr.flag.rcv_we)
                rcv_next = wr.flag.rcv;
            if (wr.flag.fany_we)
                fany_next = wr.flag.fany;
            if (wr.flag.fpid_we)
                fpid_next = wr.flag.fpid;
        end
        if (wr.link.en && wr.link.tid == MY_ID)
            nlink_next = wr.link.val;
        if (wr.head.en && wr.head.tid == MY_ID)
            qhead_next = wr.head.val;
        if (wr.tail.en && wr.tail.tid == MY_ID)
            qtail_next = wr.tail.val;
    end

    assign hold_hit = wr.hold.en && wr.hold.tid == MY_ID;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_reg   <= 1'b0;
            rcv_reg   <= 1'b0;
            fany_reg  <= 1'b1;
            fpid_reg  <= '0;
            nlink_reg <= LNK_NIL;
            qhead_reg <= LNK_NIL;
            qtail_reg <= LNK_NIL;
        end
        else
        begin
            snd_reg   <= snd_next;
            rcv_reg   <= rcv_next;
            fany_reg  <= fany_next;
            fpid_reg  <= fpid_next;
            nlink_reg <= nlink_next;
            qhead_reg <= qhead_next;
            qtail_reg <= qtail_next;
        end
    end

    // Held message: only read while the thread waits as a sender
    always_ff @(posedge clk)
    begin
        if (hold_hit)
        begin
            hpid_reg  <= wr.hold.pid;
            htype_reg <= wr.hold.mtype;
            hval_reg  <= wr.hold.mval;
            waits_reg <= wr.hold.waits;
        end
    end

    always_comb
    begin
        me.snd   = snd_reg;
        me.rcv   = rcv_reg;
        me.fany  = fany_reg;
        me.fpid  = fpid_reg;
        me.hpid  = hpid_reg;
        me.htype = htype_reg;
        me.hval  = hval_reg;
        me.waits = waits_reg;
        me.nlink = nlink_reg;
        me.qhead = qhead_reg;
        me.qtail = qtail_reg;
    end

    // Merge this cell into the read chains when selected
    assign rd_a_out = cell_rd_t'(rd_a_in | ((sel_a == MY_ID) ? me : '0));
    assign rd_b_out = cell_rd_t'(rd_b_in | ((sel_b == MY_ID) ? me : '0));

endmodule

// ----- rtl/rendezvous_message_queue_engine.sv -----
// ----------------------------------------------------------------------------
// Rendezvous message queue engine
// Send, receive and abort over per-thread sender FIFOs held in a row of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy drops in the
// cycle that shows the request's last result, so the next request can be
// taken at the edge that ends that cycle. Results appear on strobe at most
// one per cycle, each for exactly one cycle. The receiver cannot hold them
// off, so it must take every strobed item.
// Send: fails or blocks in the check step; a handover adds a done step.
// Receive: walks the queued senders and blocks at the end of the queue, or
// unlinks and wakes the first sender that passes the filter.
// Abort: clears the target, then fails each queued sender in order. A target
// that waits as a sender is first unlinked from the queue it waits in.
// The queue walks step one link per cycle through the cell read chains.
`include "rendezvous_message_queue_engine_defines.svh"

module rendezvous_message_queue_engine
    import rmqe_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  actor_thread,
    input  logic [15:0] actor_pid,
    input  logic [3:0]  dest_thread,
    input  logic        dest_alive,
    input  logic        from_any,
    input  logic [15:0] from_pid,
    input  logic [31:0] msg_type,
    input  logic [63:0] msg_value,
    output logic        strobe,
    output logic [3:0]  thread_id,
    output logic [2:0]  event_kind,
    output logic [15:0] out_source_pid,
    output logic [31:0] out_type,
    output logic [63:0] out_value,
    output logic        last
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_CHECK     = 10'b0000000010,
        ST_SEND_DONE = 10'b0000000100,
        ST_WALK      = 10'b0000001000,
        ST_RM_HEAD   = 10'b0000010000,
        ST_RM_WALK   = 10'b0000100000,
        ST_UNLINK    = 10'b0001000000,
        ST_UNLINK2   = 10'b0010000000,
        ST_ACLR      = 10'b0100000000,
        ST_DRAIN     = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  req_reg;
    logic [3:0]  actor_reg;
    logic [3:0]  dest_reg;
    logic        alive_reg;
    logic        any_reg;
    logic [15:0] fpid_reg;
    logic [15:0] mpid_reg, mpid_next;
    logic [31:0] mtype_reg, mtype_next;
    logic [63:0] mval_reg, mval_next;
    lnk_t        cur_reg, cur_next;
    lnk_t        prev_reg, prev_next;
    tid_t        q_reg, q_next;

    logic        strobe_reg;
    logic [3:0]  tid_reg;
    event_t      kind_reg;
    logic [15:0] opid_reg;
    logic [31:0] otype_reg;
    logic [63:0] oval_reg;
    logic        last_reg;

    logic        emit_en;
    tid_t        emit_tid;
    event_t      emit_kind;
    logic        emit_data;
    logic        emit_last;

    wr_t         wr;
    tid_t        sel_a, sel_b;
    cell_rd_t    chain_a [0:THREADS];
    cell_rd_t    chain_b [0:THREADS];
    cell_rd_t    rd_a, rd_b;

    logic        accept;
    tid_t        a_idx, d_idx, cur_idx;
    logic        a_oor, d_oor, req_bad, blocked, matched;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign a_idx   = TID_W'(actor_reg);
    assign d_idx   = TID_W'(dest_reg);
    assign cur_idx = cur_reg[TID_W-1:0];
    assign a_oor   = (int'(actor_reg) >= THREADS);
    assign d_oor   = (int'(dest_reg) >= THREADS);
    assign req_bad = !(req_reg == REQ_SEND || req_reg == REQ_RECV || req_reg == REQ_ABORT);
    assign blocked = (req_reg != REQ_ABORT) && (rd_a.snd || rd_a.rcv);
    assign matched = any_reg || (rd_b.hpid == fpid_reg);

    // Thread cells and their read chains
    assign chain_a[0] = '0;
    assign chain_b[0] = '0;

    for (genvar i = 0; i < THREADS; i++)
    begin : g_cell
        rmqe_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr       (wr),
            .sel_a    (sel_a),
            .sel_b    (sel_b),
            .rd_a_in  (chain_a[i]),
            .rd_b_in  (chain_b[i]),
            .rd_a_out (chain_a[i+1]),
            .rd_b_out (chain_b[i+1])
        );
    end

    assign rd_a = chain_a[THREADS];
    assign rd_b = chain_b[THREADS];

    // Pick read addresses for each step
    always_comb
    begin
        sel_a = a_idx;
        sel_b = cur_idx;
        unique case (state_reg)
            ST_CHECK:
                sel_b = d_idx;
            ST_RM_HEAD,
            ST_UNLINK:
                sel_a = q_reg;
            default:
            begin
                sel_a = a_idx;
                sel_b = cur_idx;
            end
        endcase
    end

    // Sequence one request
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        q_next     = q_reg;
        mpid_next  = mpid_reg;
        mtype_next = mtype_reg;
        mval_next  = mval_reg;
        wr         = '0;
        emit_en    = 1'b0;
        emit_tid   = a_idx;
        emit_kind  = EV_ERROR;
        emit_data  = 1'b0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                    mpid_next  = actor_pid;
                    mtype_next = msg_type;
                    mval_next  = msg_value;
                end
            end
            ST_CHECK:
            begin
                if (req_bad || a_oor || blocked)
                begin
                    emit_en    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (req_reg == REQ_SEND)
                begin
                    if (d_idx == a_idx || d_oor || !alive_reg)
                    begin
                        emit_en    = 1'b1;
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (rd_b.rcv && (rd_b.fany || rd_b.fpid == mpid_reg))
                    begin
                        // Hand over to the waiting receiver
                        wr.flag.en      = 1'b1;
                        wr.flag.tid     = d_idx;
                        wr.flag.rcv_we  = 1'b1;
                        wr.flag.rcv     = 1'b0;
                        wr.flag.fany_we = 1'b1;
                        wr.flag.fany    = 1'b1;
                        emit_en    = 1'b1;
                        emit_tid   = d_idx;
                        emit_kind  = EV_GETS_MSG;
                        emit_data  = 1'b1;
                        state_next = ST_SEND_DONE;
                    end
                    else
                    begin
                        // Hold the message and append the sender
                        wr.hold.en     = 1'b1;
                        wr.hold.tid    = a_idx;
                        wr.hold.pid    = mpid_reg;
                        wr.hold.mtype  = mtype_reg;
                        wr.hold.mval   = mval_reg;
                        wr.hold.waits  = d_idx;
                        wr.flag.en     = 1'b1;
                        wr.flag.tid    = a_idx;
                        wr.flag.snd_we = 1'b1;
                        wr.flag.snd    = 1'b1;
                        if (!rd_b.qtail[LNK_W-1])
                        begin
                            wr.link.en  = 1'b1;
                            wr.link.tid = rd_b.qtail[TID_W-1:0];
                            wr.link.val = to_lnk(a_idx);
                        end
                        else
                        begin
                            wr.head.en  = 1'b1;
                            wr.head.tid = d_idx;
                            wr.head.val = to_lnk(a_idx);
                        end
                        wr.tail.en = 1'b1;
                        wr.tail.tid = d_idx;
                        wr.tail.val = to_lnk(a_idx);
                        emit_en    = 1'b1;
                        emit_kind  = EV_BLOCKS;
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (req_reg == REQ_RECV)
                begin
                    wr.flag.en      = 1'b1;
                    wr.flag.tid     = a_idx;
                    wr.flag.fany_we = 1'b1;
                    wr.flag.fany    = any_reg;
                    wr.flag.fpid_we = 1'b1;
                    wr.flag.fpid    = fpid_reg;
                    q_next     = a_idx;
                    cur_next   = rd_a.qhead;
                    prev_next  = LNK_NIL;
                    state_next = ST_WALK;
                end
                else
                begin
                    q_next     = rd_a.waits;
                    state_next = rd_a.snd ? ST_RM_HEAD : ST_ACLR;
                end
            end
            ST_SEND_DONE:
            begin
                emit_en    = 1'b1;
                emit_kind  = EV_SEND_DONE;
                emit_last  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (cur_reg[LNK_W-1])
                begin
                    // No sender passes the filter: block the caller
                    wr.flag.en     = 1'b1;
                    wr.flag.tid    = a_idx;
                    wr.flag.rcv_we = 1'b1;
                    wr.flag.rcv    = 1'b1;
                    emit_en    = 1'b1;
                    emit_kind  = EV_BLOCKS;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (matched)
                begin
                    mpid_next  = rd_b.hpid;
                    mtype_next = rd_b.htype;
                    mval_next  = rd_b.hval;
                    state_next = ST_UNLINK;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_b.nlink;
                end
            end
            ST_RM_HEAD:
            begin
                cur_next   = rd_a.qhead;
                prev_next  = LNK_NIL;
                state_next = ST_RM_WALK;
            end
            ST_RM_WALK:
            begin
                if (cur_reg[LNK_W-1])
                    state_next = ST_ACLR;
                else if (cur_idx == a_idx)
                    state_next = ST_UNLINK;
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_b.nlink;
                end
            end
            ST_UNLINK:
            begin
                // Bridge around the entry and fix the tail
                if (prev_reg[LNK_W-1])
                begin
                    wr.head.en  = 1'b1;
                    wr.head.tid = q_reg;
                    wr.head.val = rd_b.nlink;
                end
                else
                begin
                    wr.link.en  = 1'b1;
                    wr.link.tid = prev_reg[TID_W-1:0];
                    wr.link.val = rd_b.nlink;
                end
                if (rd_a.qtail == cur_reg)
                begin
                    wr.tail.en  = 1'b1;
                    wr.tail.tid = q_reg;
                    wr.tail.val = prev_reg;
                end
                if (req_reg == REQ_RECV)
                begin
                    wr.flag.en     = 1'b1;
                    wr.flag.tid    = cur_idx;
                    wr.flag.snd_we = 1'b1;
                    wr.flag.snd    = 1'b0;
                    emit_en   = 1'b1;
                    emit_tid  = cur_idx;
                    emit_kind = EV_WOKEN_OK;
                end
                state_next = ST_UNLINK2;
            end
            ST_UNLINK2:
            begin
                wr.link.en  = 1'b1;
                wr.link.tid = cur_idx;
                wr.link.val = LNK_NIL;
                if (req_reg == REQ_RECV)
                begin
                    wr.flag.en      = 1'b1;
                    wr.flag.tid     = a_idx;
                    wr.flag.fany_we = 1'b1;
                    wr.flag.fany    = 1'b1;
                    emit_en    = 1'b1;
                    emit_kind  = EV_GETS_MSG;
                    emit_data  = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_ACLR;
            end
            ST_ACLR:
            begin
                // Clear the target and detach its sender queue
                wr.flag.en      = 1'b1;
                wr.flag.tid     = a_idx;
                wr.flag.snd_we  = 1'b1;
                wr.flag.snd     = 1'b0;
                wr.flag.rcv_we  = 1'b1;
                wr.flag.rcv     = 1'b0;
                wr.flag.fany_we = 1'b1;
                wr.flag.fany    = 1'b1;
                wr.flag.fpid_we = 1'b1;
                wr.flag.fpid    = '0;
                wr.head.en      = 1'b1;
                wr.head.tid     = a_idx;
                wr.head.val     = LNK_NIL;
                wr.tail.en      = 1'b1;
                wr.tail.tid     = a_idx;
                wr.tail.val     = LNK_NIL;
                cur_next   = rd_a.qhead;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                emit_en = 1'b1;
                if (cur_reg[LNK_W-1])
                begin
                    emit_kind  = EV_ABORT_DONE;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Fail one queued sender and advance
                    wr.link.en     = 1'b1;
                    wr.link.tid    = cur_idx;
                    wr.link.val    = LNK_NIL;
                    wr.flag.en     = 1'b1;
                    wr.flag.tid    = cur_idx;
                    wr.flag.snd_we = 1'b1;
                    wr.flag.snd    = 1'b0;
                    emit_tid  = cur_idx;
                    emit_kind = EV_WOKEN_FAIL;
                    cur_next  = rd_b.nlink;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit_en;
        end
    end

    // Request latch, walk pointers and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            actor_reg <= actor_thread;
            dest_reg  <= dest_thread;
            alive_reg <= dest_alive;
            any_reg   <= from_any;
            fpid_reg  <= from_pid;
        end
        mpid_reg  <= mpid_next;
        mtype_reg <= mtype_next;
        mval_reg  <= mval_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        q_reg     <= q_next;
        if (emit_en)
        begin
            tid_reg   <= emit_tid[3:0];
            kind_reg  <= emit_kind;
            opid_reg  <= emit_data ? mpid_reg : 16'd0;
            otype_reg <= emit_data ? mtype_reg : 32'd0;
            oval_reg  <= emit_data ? mval_reg : 64'd0;
            last_reg  <= emit_last;
        end
    end

    assign strobe         = strobe_reg;
    assign thread_id      = tid_reg;
    assign event_kind     = kind_reg;
    assign out_source_pid = opid_reg;
    assign out_type       = otype_reg;
    assign out_value      = oval_reg;
    assign last           = last_reg;

    // Checks
    `RMQE_ASSERT_IMP(a_last_frees, clk, rst_n, strobe && last, !busy)
    `RMQE_ASSERT_IMP(a_more_busy, clk, rst_n, strobe && !last, busy)
    `RMQE_ASSERT_NXT(a_accept_quiet, clk, rst_n, start && !busy, busy && !strobe)
    `RMQE_ASSERT_IMP(a_zero_payload, clk, rst_n, strobe && event_kind != EV_GETS_MSG, out_source_pid == 16'd0 && out_type == 32'd0 && out_value == 64'd0)

endmodule

// ----- bench/rendezvous_message_queue_engine_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rendezvous message queue engine testbench
// Drives send, receive, abort and invalid requests with directed and random items,
// predicts every result from a behavioral copy of the thread state and checks
// each strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rendezvous_message_queue_engine_test;
    import rmqe_pkg::*;

    localparam int NTHR = 16;
    localparam int EMPTY = -1;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] REQ_BAD = 2'd3;

    typedef struct {
        bit [1:0]  kind;
        bit [3:0]  actor;
        bit [15:0] apid;
        bit [3:0]  dest;
        bit        alive;
        bit        any;
        bit [15:0] fpid;
        bit [31:0] mtype;
        bit [63:0] mval;
    } request_t;

    typedef struct {
        bit [3:0]  tid;
        event_t    kind;
        bit [15:0] pid;
        bit [31:0] mtype;
        bit [63:0] mval;
        bit        lst;
    } event_rec_t;

    // Scoreboard: mailbox state mirror and queue of predicted events
    class mailbox_scoreboard;
        bit        sending[NTHR];
        bit        receiving[NTHR];
        bit        fany[NTHR];
        bit [15:0] fpid[NTHR];
        bit [15:0] hpid[NTHR];
        bit [31:0] htype[NTHR];
        bit [63:0] hval[NTHR];
        int        waits[NTHR];
        int        nxt[NTHR];
        int        head[NTHR];
        int        tail[NTHR];
        event_rec_t pending[$];
        int        errors;

        function void clear();
            for (int t = 0; t < NTHR; t++)
            begin
                sending[t] = 0; receiving[t] = 0; fany[t] = 1; fpid[t] = 0;
                hpid[t] = 0; htype[t] = 0; hval[t] = 0; waits[t] = 0;
                nxt[t] = EMPTY; head[t] = EMPTY; tail[t] = EMPTY;
            end
            pending.delete();
            errors = 0;
        endfunction

        function bit blocked(int t);
            return sending[t] || receiving[t];
        endfunction

        function void post(int tid, event_t kind, bit [15:0] pid = 0,
                           bit [31:0] mt = 0, bit [63:0] mv = 0);
            event_rec_t e;
            e.tid = tid; e.kind = kind; e.pid = pid; e.mtype = mt; e.mval = mv;
            e.lst = 0;
            pending.push_back(e);
        endfunction

        // Unlink s (after prev, or head when prev is empty) from queue q
        function void unlink(int q, int prev, int s);
            if (prev != EMPTY) nxt[prev] = nxt[s];
            else head[q] = nxt[s];
            if (tail[q] == s) tail[q] = prev;
            nxt[s] = EMPTY;
        endfunction

        // Note an accepted item and predict its events
        function void note(request_t r);
            int a, d, prev, s, cnt, nx;
            a = r.actor; d = r.dest;
            if (r.kind == REQ_BAD || (r.kind != REQ_ABORT && blocked(a)))
                post(a, EV_ERROR);
            else if (r.kind == REQ_SEND)
            begin
                if (d == a || !r.alive)
                    post(a, EV_ERROR);
                else if (receiving[d] && (fany[d] || fpid[d] == r.apid))
                begin
                    receiving[d] = 0; fany[d] = 1;
                    post(d, EV_GETS_MSG, r.apid, r.mtype, r.mval);
                    post(a, EV_SEND_DONE);
                end
                else
                begin
                    hpid[a] = r.apid; htype[a] = r.mtype; hval[a] = r.mval;
                    sending[a] = 1; waits[a] = d;
                    nxt[a] = EMPTY;
                    if (tail[d] != EMPTY) nxt[tail[d]] = a;
                    else head[d] = a;
                    tail[d] = a;
                    post(a, EV_BLOCKS);
                end
            end
            else if (r.kind == REQ_RECV)
            begin
                prev = EMPTY; s = head[a]; cnt = 0;
                fany[a] = r.any; fpid[a] = r.fpid;
                while (s != EMPTY && cnt < NTHR && !(r.any || hpid[s] == r.fpid))
                begin
                    prev = s; s = nxt[s]; cnt++;
                end
                if (s != EMPTY && (r.any || hpid[s] == r.fpid))
                begin
                    unlink(a, prev, s);
                    sending[s] = 0; waits[s] = 0; fany[a] = 1;
                    post(s, EV_WOKEN_OK);
                    post(a, EV_GETS_MSG, hpid[s], htype[s], hval[s]);
                end
                else
                begin
                    receiving[a] = 1;
                    post(a, EV_BLOCKS);
                end
            end
            else
            begin
                // Drop the target from the queue it waits in
                if (sending[a])
                begin
                    prev = EMPTY; s = head[waits[a]]; cnt = 0;
                    while (s != EMPTY && s != a && cnt < NTHR)
                    begin
                        prev = s; s = nxt[s]; cnt++;
                    end
                    if (s == a) unlink(waits[a], prev, a);
                end
                sending[a] = 0; receiving[a] = 0; waits[a] = 0;
                fany[a] = 1; fpid[a] = 0;
                s = head[a]; head[a] = EMPTY; tail[a] = EMPTY; cnt = 0;
                // Fail every queued sender in order
                while (s != EMPTY && cnt < NTHR - 1)
                begin
                    nx = nxt[s]; nxt[s] = EMPTY;
                    sending[s] = 0; waits[s] = 0;
                    post(s, EV_WOKEN_FAIL);
                    s = nx; cnt++;
                end
                post(a, EV_ABORT_DONE);
            end
            pending[pending.size() - 1].lst = 1;
        endfunction

        function void field(string name, bit [63:0] exp, bit [63:0] act);
            if (exp !== act)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Check one strobed event against the oldest prediction
        function void check(event_rec_t got);
            event_rec_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected event expected none actual thread %0d kind %0d",
                         $time, got.tid, got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("thread_id", e.tid, got.tid);
            field("event_kind", e.kind, got.kind);
            field("out_source_pid", e.pid, got.pid);
            field("out_type", e.mtype, got.mtype);
            field("out_value", e.mval, got.mval);
            field("last", e.lst, got.lst);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  req_type = 0;
    logic [3:0]  actor_thread = 0;
    logic [15:0] actor_pid = 0;
    logic [3:0]  dest_thread = 0;
    logic        dest_alive = 0;
    logic        from_any = 0;
    logic [15:0] from_pid = 0;
    logic [31:0] msg_type = 0;
    logic [63:0] msg_value = 0;
    logic        strobe;
    logic [3:0]  thread_id;
    logic [2:0]  event_kind;
    logic [15:0] out_source_pid;
    logic [31:0] out_type;
    logic [63:0] out_value;
    logic        last;

    mailbox_scoreboard sb = new();
    int stall_count = 0;

    rendezvous_message_queue_engine dut (.*);

    always #2 clk = ~clk;

    // Check every strobed event
    always @(posedge clk)
    begin
        event_rec_t got;
        if (rst_n && strobe)
        begin
            got.tid = thread_id; got.kind = event_t'(event_kind);
            got.pid = out_source_pid; got.mtype = out_type; got.mval = out_value;
            got.lst = last;
            sb.check(got);
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (strobe === 1'b1 || (start && busy === 1'b0))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("rendezvous_message_queue_engine test failed");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    function automatic request_t mk_send(int a, bit [15:0] pid, int d, bit alive = 1,
                                         bit [31:0] mt = 32'h5, bit [63:0] mv = 64'h9);
        request_t r = '{default: 0};
        r.kind = REQ_SEND; r.actor = a; r.apid = pid; r.dest = d; r.alive = alive;
        r.mtype = mt; r.mval = mv;
        return r;
    endfunction

    function automatic request_t mk_recv(int a, bit any, bit [15:0] pid);
        request_t r = '{default: 0};
        r.kind = REQ_RECV; r.actor = a; r.any = any; r.fpid = pid;
        return r;
    endfunction

    function automatic request_t mk_abort(int a);
        request_t r = '{default: 0};
        r.kind = REQ_ABORT; r.actor = a;
        return r;
    endfunction

    function automatic bit [15:0] pick_pid();
        bit [15:0] pool[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};
        if ($urandom_range(99) < 80) return pool[$urandom_range(3)];
        return $urandom;
    endfunction

    // Random request, mostly from threads that are free to act
    function automatic request_t mk_random();
        request_t r;
        int roll;
        r.actor = $urandom_range(NTHR - 1);
        if ($urandom_range(99) < 85)
            for (int k = 0; k < NTHR && sb.blocked(r.actor); k++)
                r.actor = $urandom_range(NTHR - 1);
        roll = $urandom_range(99);
        r.kind = roll < 45 ? REQ_SEND : roll < 80 ? REQ_RECV : roll < 95 ? REQ_ABORT : REQ_BAD;
        r.apid = pick_pid();
        r.dest = ($urandom_range(99) < 5) ? r.actor : 4'($urandom_range(NTHR - 1));
        r.alive = $urandom_range(99) < 95;
        r.any = $urandom_range(99) < 40;
        r.fpid = pick_pid();
        r.mtype = $urandom;
        r.mval = {$urandom, $urandom};
        return r;
    endfunction

    // Present one item and hold it until accepted
    task automatic drive(request_t r, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        req_type <= r.kind; actor_thread <= r.actor; actor_pid <= r.apid;
        dest_thread <= r.dest; dest_alive <= r.alive; from_any <= r.any;
        from_pid <= r.fpid; msg_type <= r.mtype; msg_value <= r.mval;
        start <= 1;
        do @(posedge clk); while (busy);
        sb.note(r);
    endtask

    // Hold off until every predicted event has arrived
    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int idle_pct;
        sb.clear();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: errors, selective receive, unlink, handover, full drain
        drive(mk_send(1, 16'h1, 1), 0);
        drive(mk_send(1, 16'h1, 2, 0), 0);
        drive(mk_send(1, 16'hFFFF, 0, 1, '1, '1), 0);
        drive(mk_send(2, 16'h0000, 0, 1, '0, '0), 0);
        drive(mk_send(1, 16'h1, 3), 0);
        drive(mk_recv(0, 0, 16'h0000), 0);
        drive(mk_abort(1), 0);
        drive(mk_recv(0, 0, 16'h1234), 0);
        drive(mk_send(3, 16'h00A5, 0), 0);
        drive(mk_send(4, 16'h1234, 0, 1, 32'hDEADBEEF, 64'h0123456789ABCDEF), 0);
        drive(mk_recv(0, 1, 16'h0), 0);
        begin
            request_t r = mk_abort(15);
            r.kind = REQ_BAD;
            drive(r, 0);
        end
        for (int t = 1; t < NTHR; t++)
            if (!sb.blocked(t)) drive(mk_send(t, 16'h00A5, 0), 0);
        drive(mk_abort(0), 0);
        drain();

        // Random phases with different sender idle rates
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = ph == 0 ? 11 : ph == 1 ? 58 : 0;
            for (int i = 0; i < 100; i++)
                drive(mk_random(), idle_pct);
            if (ph == 0) drain();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rendezvous_message_queue_engine test passed");
        else
            $display("rendezvous_message_queue_engine test failed");
        $finish;
    end
endmodule
